### hw/rtl/slxfp_pkg.sv
// shared types and constants for the sync/length/xor frame parser
// no dependencies; imported by the parser top level

package slxfp_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_CHAN  = 3'd2,
    PH_LENH  = 3'd3,
    PH_LENL  = 3'd4,
    PH_DATA  = 3'd5,
    PH_CHECK = 3'd6
  } phase_t;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_END_GOOD = 2'd1,
    KIND_END_BAD  = 2'd2
  } kind_t;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CMD_START  = 3'd0;
  localparam logic [2:0] REG_REPLY_START = 3'd1;
  localparam logic [2:0] REG_SYNC2      = 3'd2;
  localparam logic [2:0] REG_CTRL_CHAN  = 3'd3;
  localparam logic [2:0] REG_MAX_LEN    = 3'd4;

  // register reset values
  localparam logic [7:0]  CMD_START_RST   = 8'hAA;
  localparam logic [7:0]  REPLY_START_RST = 8'hBB;
  localparam logic [7:0]  SYNC2_RST       = 8'h55;
  localparam logic [7:0]  CTRL_CHAN_RST   = 8'hE0;
  localparam logic [15:0] MAX_LEN_RST     = 16'd256;

  // configuration port widths
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // one result transaction
  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  channel_id;
    logic [15:0] frame_length;
    logic        is_control;
    logic [31:0] good_frame_count;
  } result_t;

endpackage

### hw/rtl/slxfp_in_if.sv
// input byte channel of the frame parser
// plain valid/ready handshake, no dependencies

interface slxfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/slxfp_out_if.sv
// result channel of the frame parser
// plain valid/ready handshake, no dependencies

interface slxfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [7:0]  channel_id;
  logic [15:0] frame_length;
  logic        is_control;
  logic [31:0] good_frame_count;

  modport source (
    output valid, output result_kind, output payload_byte, output payload_index,
    output channel_id, output frame_length, output is_control,
    output good_frame_count, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input payload_index,
    input channel_id, input frame_length, input is_control,
    input good_frame_count, output ready
  );
endinterface

### hw/rtl/sync_length_xor_frame_parser_top.sv
// frame parser top level: sync hunt, header, cut-through payload, xor check
// depends on slxfp_pkg, slxfp_in_if and slxfp_out_if
// a result is registered from the byte that causes it, into the result register or the skid entry
// one byte per cycle while the skid entry is empty; the parse state updates once per accepted byte
// a two-entry output buffer (result register plus skid) takes stalls on the result side
// reset (rst, synchronous): hunting, counters and xor cleared, registers to defaults

module sync_length_xor_frame_parser_top
  import slxfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  slxfp_in_if.sink            in_ch,
  slxfp_out_if.source         out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // configuration registers
  logic [7:0]  command_start_byte;
  logic [7:0]  reply_start_byte;
  logic [7:0]  second_sync_byte;
  logic [7:0]  control_channel;
  logic [15:0] max_payload_length;

  // parse state
  phase_t      phase, phase_next;
  logic [7:0]  channel, channel_next;
  logic [15:0] length, length_next;
  logic [7:0]  run_xor, run_xor_next;
  logic [15:0] byte_cnt, byte_cnt_next;
  logic [31:0] good_cnt, good_cnt_next;

  // output buffer
  logic        out_valid;
  result_t     out_res;
  logic        skid_valid;
  result_t     skid_res;

  logic        res_valid;
  result_t     res;
  logic        in_take;
  logic        out_take;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic [7:0]  b;
  logic [15:0] len_full;
  logic [16:0] cnt_inc;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = paddr[4:2];
  assign in_ch.ready = ~skid_valid;
  assign in_take  = in_ch.valid & ~skid_valid;
  assign out_take = out_valid & out_ch.ready;
  assign b        = in_ch.rx_byte;
  assign len_full = {length[15:8], b};
  assign cnt_inc  = {1'b0, byte_cnt} + 17'd1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      command_start_byte <= CMD_START_RST;
      reply_start_byte   <= REPLY_START_RST;
      second_sync_byte   <= SYNC2_RST;
      control_channel    <= CTRL_CHAN_RST;
      max_payload_length <= MAX_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CMD_START:   command_start_byte <= pwdata[7:0];
        REG_REPLY_START: reply_start_byte   <= pwdata[7:0];
        REG_SYNC2:       second_sync_byte   <= pwdata[7:0];
        REG_CTRL_CHAN:   control_channel    <= pwdata[7:0];
        REG_MAX_LEN:     max_payload_length <= pwdata[15:0];
        default:         ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_CMD_START:   prdata = {24'd0, command_start_byte};
      REG_REPLY_START: prdata = {24'd0, reply_start_byte};
      REG_SYNC2:       prdata = {24'd0, second_sync_byte};
      REG_CTRL_CHAN:   prdata = {24'd0, control_channel};
      REG_MAX_LEN:     prdata = {16'd0, max_payload_length};
      default:         prdata = '0;
    endcase
  end

  // next parse state and result for the byte on the input
  always_comb begin
    phase_next    = phase;
    channel_next  = channel;
    length_next   = length;
    run_xor_next  = run_xor;
    byte_cnt_next = byte_cnt;
    good_cnt_next = good_cnt;
    res_valid     = 1'b0;
    res.result_kind   = KIND_PAYLOAD;
    res.payload_byte  = 8'd0;
    res.payload_index = 16'd0;
    if (in_take) begin
      case (phase)
        PH_HUNT: begin
          if (b == command_start_byte || b == reply_start_byte) phase_next = PH_SYNC2;
        end
        PH_SYNC2: begin
          phase_next = (b == second_sync_byte) ? PH_CHAN : PH_HUNT;
        end
        PH_CHAN: begin
          channel_next = b;
          run_xor_next = b;
          phase_next   = PH_LENH;
        end
        PH_LENH: begin
          length_next  = {b, 8'd0};
          run_xor_next = run_xor ^ b;
          phase_next   = PH_LENL;
        end
        PH_LENL: begin
          length_next   = len_full;
          run_xor_next  = run_xor ^ b;
          byte_cnt_next = 16'd0;
          if (len_full == 16'd0 || len_full > max_payload_length) phase_next = PH_HUNT;
          else phase_next = PH_DATA;
        end
        PH_DATA: begin
          run_xor_next  = run_xor ^ b;
          byte_cnt_next = cnt_inc[15:0];
          if (cnt_inc >= {1'b0, length}) phase_next = PH_CHECK;
          res_valid         = 1'b1;
          res.payload_byte  = b;
          res.payload_index = byte_cnt;
        end
        PH_CHECK: begin
          phase_next = PH_HUNT;
          res_valid  = 1'b1;
          if (b == run_xor) begin
            good_cnt_next   = good_cnt + 32'd1;
            res.result_kind = KIND_END_GOOD;
          end else begin
            res.result_kind = KIND_END_BAD;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
    res.channel_id       = channel_next;
    res.frame_length     = length_next;
    res.is_control       = (channel_next == control_channel);
    res.good_frame_count = good_cnt_next;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      channel  <= 8'd0;
      length   <= 16'd0;
      run_xor  <= 8'd0;
      byte_cnt <= 16'd0;
      good_cnt <= 32'd0;
    end else begin
      phase    <= phase_next;
      channel  <= channel_next;
      length   <= length_next;
      run_xor  <= run_xor_next;
      byte_cnt <= byte_cnt_next;
      good_cnt <= good_cnt_next;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_take) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // result channel
  assign out_ch.valid            = out_valid;
  assign out_ch.result_kind      = out_res.result_kind;
  assign out_ch.payload_byte     = out_res.payload_byte;
  assign out_ch.payload_index    = out_res.payload_index;
  assign out_ch.channel_id       = out_res.channel_id;
  assign out_ch.frame_length     = out_res.frame_length;
  assign out_ch.is_control       = out_res.is_control;
  assign out_ch.good_frame_count = out_res.good_frame_count;

endmodule

### test/slxfp_checker.sv
// scoreboard for the frame parser: mirrors the register writes on the config port,
// predicts every result from the accepted input bytes and compares the output channel
// depends on slxfp_pkg, slxfp_in_if and slxfp_out_if

module slxfp_checker
  import slxfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  slxfp_in_if               in_mon,
  slxfp_out_if              out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [7:0]  cmd_start;
  logic [7:0]  reply_start;
  logic [7:0]  sync2_byte;
  logic [7:0]  ctrl_chan;
  logic [15:0] max_len;

  // parser state copy
  phase_t      phase;
  logic [7:0]  chan;
  logic [15:0] decl_len;
  logic [7:0]  xsum;
  logic [15:0] rcvd;
  logic [31:0] good_cnt;

  // results still to come out of the block, oldest first
  result_t     parsed_q[$];

  function automatic result_t make_result(kind_t kind, logic [7:0] data, logic [15:0] idx);
    result_t r;
    r.result_kind      = kind;
    r.payload_byte     = data;
    r.payload_index    = idx;
    r.channel_id       = chan;
    r.frame_length     = decl_len;
    r.is_control       = (chan == ctrl_chan);
    r.good_frame_count = good_cnt;
    return r;
  endfunction

  // one byte through the parser; returns 1 when it yields a result
  function automatic bit parse_rx_byte(logic [7:0] b, output result_t r);
    logic [15:0] idx;
    r = '0;
    case (phase)
      PH_HUNT: begin
        if (b == cmd_start || b == reply_start) phase = PH_SYNC2;
        return 1'b0;
      end
      PH_SYNC2: begin
        // a wrong second byte is not reused as a start byte
        phase = (b == sync2_byte) ? PH_CHAN : PH_HUNT;
        return 1'b0;
      end
      PH_CHAN: begin
        chan  = b;
        xsum  = b;
        phase = PH_LENH;
        return 1'b0;
      end
      PH_LENH: begin
        decl_len = {b, 8'h00};
        xsum     = xsum ^ b;
        phase    = PH_LENL;
        return 1'b0;
      end
      PH_LENL: begin
        // limit taken as it stands when the low length byte arrives
        decl_len = decl_len | {8'h00, b};
        xsum     = xsum ^ b;
        rcvd     = '0;
        phase    = (decl_len == 0 || decl_len > max_len) ? PH_HUNT : PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        idx  = rcvd;
        xsum = xsum ^ b;
        rcvd = rcvd + 16'd1;
        if (rcvd >= decl_len) phase = PH_CHECK;
        r = make_result(KIND_PAYLOAD, b, idx);
        return 1'b1;
      end
      PH_CHECK: begin
        phase = PH_HUNT;
        if (b == xsum) begin
          good_cnt = good_cnt + 32'd1;
          r = make_result(KIND_END_GOOD, 8'h00, 16'h0000);
        end else begin
          r = make_result(KIND_END_BAD, 8'h00, 16'h0000);
        end
        return 1'b1;
      end
      default: begin
        phase = PH_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // watch both channels and the config port at every edge
  always @(posedge clk) begin
    result_t want;
    result_t next_r;
    if (rst) begin
      cmd_start   = CMD_START_RST;
      reply_start = REPLY_START_RST;
      sync2_byte  = SYNC2_RST;
      ctrl_chan   = CTRL_CHAN_RST;
      max_len     = MAX_LEN_RST;
      phase       = PH_HUNT;
      chan        = '0;
      decl_len    = '0;
      xsum        = '0;
      rcvd        = '0;
      good_cnt    = '0;
      parsed_q.delete();
      outstanding <= 0;
    end else begin
      // register write
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (paddr[ADDR_W-1:2])
          REG_CMD_START:   cmd_start   = pwdata[7:0];
          REG_REPLY_START: reply_start = pwdata[7:0];
          REG_SYNC2:       sync2_byte  = pwdata[7:0];
          REG_CTRL_CHAN:   ctrl_chan   = pwdata[7:0];
          REG_MAX_LEN:     max_len     = pwdata[15:0];
          default: ;
        endcase
      end
      // result transaction against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (parsed_q.size() == 0) begin
          $display("%0t: result with none pending: expected nothing, actual kind %0d",
                   $time, out_mon.result_kind);
          mismatches++;
        end else begin
          want = parsed_q.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_mon.result_kind));
          check_field("payload_byte", 32'(want.payload_byte), 32'(out_mon.payload_byte));
          check_field("payload_index", 32'(want.payload_index), 32'(out_mon.payload_index));
          check_field("channel_id", 32'(want.channel_id), 32'(out_mon.channel_id));
          check_field("frame_length", 32'(want.frame_length), 32'(out_mon.frame_length));
          check_field("is_control", 32'(want.is_control), 32'(out_mon.is_control));
          check_field("good_frame_count", want.good_frame_count, out_mon.good_frame_count);
        end
      end
      // input transaction
      if (in_mon.valid && in_mon.ready) begin
        if (parse_rx_byte(in_mon.rx_byte, next_r)) parsed_q.push_back(next_r);
      end
      outstanding <= parsed_q.size();
    end
  end

endmodule

### test/sync_length_xor_frame_parser_top_tb.sv
// testbench top for the frame parser: clock, reset, byte stimulus, config writes
// and receiver stalls; the checking sits in slxfp_checker beside the block
// depends on slxfp_pkg, slxfp_in_if, slxfp_out_if and slxfp_checker

module sync_length_xor_frame_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slxfp_pkg::*;

  // register index with no register behind it
  localparam logic [2:0] REG_UNUSED = 3'd5;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int unsigned       mismatches;
  int unsigned       outstanding;

  // idle rates in percent
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // register values as last written
  logic [7:0]  cfg_cmd;
  logic [7:0]  cfg_reply;
  logic [7:0]  cfg_sync2;
  logic [7:0]  cfg_ctrl;
  logic [15:0] cfg_max;

  // bytes waiting to be sent
  logic [7:0]  tx_bytes[$];

  slxfp_in_if  in_ch();
  slxfp_out_if out_ch();

  sync_length_xor_frame_parser_top DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  slxfp_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // run limit
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // one register write: setup phase, access phase held until pready, then an idle phase
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CMD_START:   cfg_cmd   = val[7:0];
      REG_REPLY_START: cfg_reply = val[7:0];
      REG_SYNC2:       cfg_sync2 = val[7:0];
      REG_CTRL_CHAN:   cfg_ctrl  = val[7:0];
      REG_MAX_LEN:     cfg_max   = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [7:0] cmd, input logic [7:0] reply,
                              input logic [7:0] sync2, input logic [7:0] ctrl,
                              input logic [15:0] max_len);
    write_reg(REG_CMD_START, DATA_W'(cmd));
    write_reg(REG_REPLY_START, DATA_W'(reply));
    write_reg(REG_SYNC2, DATA_W'(sync2));
    write_reg(REG_CTRL_CHAN, DATA_W'(ctrl));
    write_reg(REG_MAX_LEN, DATA_W'(max_len));
  endtask

  // one input transaction, with random gaps in front
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_queued();
    foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
    tx_bytes.delete();
  endtask

  // hold the sender until every result is out and the pending count stays at zero
  task automatic wait_drained();
    int unsigned quiet;
    in_ch.valid <= 1'b0;
    quiet = 0;
    while (quiet < 4) begin
      @(posedge clk);
      quiet = (outstanding == 0) ? quiet + 1 : 0;
    end
  endtask

  task automatic push_header(input logic [7:0] start, input logic [7:0] sync2,
                             input logic [7:0] chan, input logic [15:0] len);
    tx_bytes.push_back(start);
    tx_bytes.push_back(sync2);
    tx_bytes.push_back(chan);
    tx_bytes.push_back(len[15:8]);
    tx_bytes.push_back(len[7:0]);
  endtask

  // full frame with random payload; a non-zero flip spoils the checksum
  task automatic push_frame(input logic [7:0] start, input logic [7:0] sync2,
                            input logic [7:0] chan, input logic [15:0] len,
                            input logic [7:0] flip);
    logic [7:0] sum;
    logic [7:0] b;
    sum = chan ^ len[15:8] ^ len[7:0];
    push_header(start, sync2, chan, len);
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom);
      sum = sum ^ b;
      tx_bytes.push_back(b);
    end
    tx_bytes.push_back(sum ^ flip);
  endtask

  // mostly short frames, now and then a longer one
  function automatic logic [15:0] frame_len_pick();
    int unsigned cap;
    cap = (cfg_max == 0) ? 1 : int'(cfg_max);
    if ($urandom_range(0, 19) == 0) return 16'($urandom_range(1, (cap < 300) ? cap : 300));
    return 16'($urandom_range(1, (cap < 12) ? cap : 12));
  endfunction

  function automatic logic [15:0] rand_max_len();
    case ($urandom_range(0, 2))
      0: return 16'($urandom_range(1, 16));
      1: return 16'($urandom_range(17, 65535));
      default: return MAX_LEN_RST;
    endcase
  endfunction

  // random traffic: mostly whole frames, some with a spoiled checksum, the rest broken headers and line noise
  task automatic random_traffic(input int unsigned budget);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  start;
    logic [7:0]  chan;
    logic [15:0] len;
    sent = 0;
    while (sent < budget) begin
      pick  = $urandom_range(0, 99);
      start = $urandom_range(0, 1) ? cfg_cmd : cfg_reply;
      chan  = ($urandom_range(0, 3) == 0) ? cfg_ctrl : 8'($urandom);
      if (pick < 70) begin
        push_frame(start, cfg_sync2, chan, frame_len_pick(),
                   ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      end else if (pick < 80) begin
        // wrong second sync byte, sometimes followed by the right one
        tx_bytes.push_back(start);
        tx_bytes.push_back(cfg_sync2 ^ 8'($urandom_range(1, 255)));
        if ($urandom_range(0, 1) == 1) tx_bytes.push_back(cfg_sync2);
      end else if (pick < 90) begin
        // zero length or over the limit
        if (cfg_max == 16'hFFFF || $urandom_range(0, 2) == 0) len = 16'h0000;
        else len = 16'($urandom_range(int'(cfg_max) + 1, 65535));
        push_header(start, cfg_sync2, chan, len);
      end else begin
        repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
      end
      sent += tx_bytes.size();
      send_queued();
    end
  endtask

  // directed frames on the reset register values, then extreme settings
  task automatic directed_frames();
    // control channel, good checksum
    push_frame(CMD_START_RST, SYNC2_RST, CTRL_CHAN_RST, 16'd1, 8'h00);
    // reply start, bad checksum
    push_frame(REPLY_START_RST, SYNC2_RST, 8'h3C, 16'd1, 8'h80);
    // wrong second byte that is itself a start byte must not be taken as a new start
    tx_bytes.push_back(REPLY_START_RST);
    tx_bytes.push_back(CMD_START_RST);
    tx_bytes.push_back(SYNC2_RST);
    // zero length, then one over the limit
    push_header(CMD_START_RST, SYNC2_RST, 8'h01, 16'd0);
    push_header(REPLY_START_RST, SYNC2_RST, 8'h02, MAX_LEN_RST + 16'd1);
    send_queued();
    wait_drained();

    // limit of one: length at the limit passes, one more is dropped
    apply_config(8'h00, 8'hFF, 8'hFF, 8'h00, 16'd1);
    write_reg(REG_UNUSED, '1);
    push_frame(8'hFF, 8'hFF, 8'h00, 16'd1, 8'h00);
    push_header(8'h00, 8'hFF, 8'h05, 16'd2);
    send_queued();
    wait_drained();

    // limit of zero rejects everything
    write_reg(REG_MAX_LEN, '0);
    push_header(8'h00, 8'hFF, 8'h05, 16'd1);
    send_queued();
    wait_drained();
  endtask

  // main sequence
  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 47;
    cfg_cmd       = CMD_START_RST;
    cfg_reply     = REPLY_START_RST;
    cfg_sync2     = SYNC2_RST;
    cfg_ctrl      = CTRL_CHAN_RST;
    cfg_max       = MAX_LEN_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin send_idle_pct = 17; recv_idle_pct = 47; end
        1: begin send_idle_pct = 47; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (stage == 0) directed_frames();
      for (int ph = 0; ph < 2; ph++) begin
        if (stage == 0 && ph == 0) begin
          apply_config(8'hFF, 8'h00, 8'h00, 8'hFF, 16'hFFFF);
        end else begin
          apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       rand_max_len());
        end
        random_traffic(225);
        wait_drained();
      end
    end

    // largest declared length against a limit one below it, then a short frame
    write_reg(REG_MAX_LEN, DATA_W'(16'hFFFE));
    push_header(cfg_cmd, cfg_sync2, 8'($urandom), 16'hFFFF);
    push_frame(cfg_cmd, cfg_sync2, 8'($urandom), 16'd40, 8'h00);
    send_queued();
    wait_drained();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
